// ===== sv/feedback_delay_with_declick_core_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the feedback delay core
// Shorthand for clocked property checks with a common disable on reset.
// ----------------------------------------------------------------------------
`ifndef FEEDBACK_DELAY_WITH_DECLICK_CORE_ASSERT_SVH
`define FEEDBACK_DELAY_WITH_DECLICK_CORE_ASSERT_SVH

// condition holds at every clock edge outside reset
`define FDD_ASSERT_ALWAYS(name, clk, rstn, cond) \
    name: assert property (@(posedge clk) disable iff (!rstn) (cond)) \
        else $error("fdd assertion failed");

// consequent holds in the same cycle as the antecedent
`define FDD_ASSERT_NOW(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("fdd assertion failed");

// consequent holds in the cycle after the antecedent
`define FDD_ASSERT_NEXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("fdd assertion failed");

`endif

// ===== sv/fdd_pkg.sv =====
// ----------------------------------------------------------------------------
// fdd_pkg
// Widths, reset values and register map of the feedback delay core.
// ----------------------------------------------------------------------------
package fdd_pkg;

    localparam int SAMPLE_W = 24;
    localparam int DELAY_W  = 16;
    localparam int GAIN_W   = 16;
    localparam int FADE_W   = 26;
    localparam int APB_AW   = 4;
    localparam int APB_DW   = 32;

    localparam int DEF_STORE_AW = 16;
    localparam int DEF_FADE_LEN = 2000;

    // 0.9 in Q0.16
    localparam logic [GAIN_W-1:0] FB_MAX    = 16'd58982;
    localparam logic [GAIN_W-1:0] DRY_RESET = 16'd16384;
    localparam logic [GAIN_W-1:0] WET_RESET = 16'd16384;
    localparam logic [GAIN_W-1:0] FB_RESET  = 16'd0;

    typedef enum logic [APB_AW-3:0] {
        REG_DRY = 2'd0,
        REG_WET = 2'd1,
        REG_FB  = 2'd2
    } reg_idx_t;

endpackage

// ===== sv/feedback_delay_with_declick_core.sv =====
// ----------------------------------------------------------------------------
// feedback_delay_with_declick_core
// Echo line with feedback and a linear declick offset on delay changes.
// ----------------------------------------------------------------------------
// Input channel s_*: one Q1.23 sample and a delay length per transfer.
// Result channel m_*: one saturated Q1.23 mix per input transfer.
// APB port: dry gain (0x0), wet gain (0x4), feedback gain (0x8), 16 bits each.
// Items are handled one at a time; the delay line sits in a single RAM with
// one read port and one write port.
// Delay unchanged: one RAM read, issued with the transfer; the result is
//   registered into the output register from ST_NEW.
// Delay changed: the item passes ST_NEW, ST_OLD, ST_DIV, ST_FIX and ST_FIN:
//   second RAM read for the old tap, a reciprocal multiply of the
//   new offset by 1/FADE_LEN, a remainder and sign fixup, and the final
//   update; the quotient and remainder set the fade step for the ramp.
// The output register frees the input side: the next transfer is taken while
// a result still waits. If the receiver stalls, the item after it waits in
// its last cycle until the output register empties.
// Reset restores pointers, fade state and gains at once; no clearing pass is
// run over the RAM: a fill mark makes unwritten entries read as zero.
// ----------------------------------------------------------------------------
module feedback_delay_with_declick_core #(
    parameter int STORE_AW = fdd_pkg::DEF_STORE_AW,
    parameter int FADE_LEN = fdd_pkg::DEF_FADE_LEN
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [fdd_pkg::SAMPLE_W-1:0] s_sample_in,
    input  logic [fdd_pkg::DELAY_W-1:0]         s_delay_len,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [fdd_pkg::SAMPLE_W-1:0] m_sample_out,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [fdd_pkg::APB_AW-1:0]          paddr,
    input  logic [fdd_pkg::APB_DW-1:0]          pwdata,
    output logic [fdd_pkg::APB_DW-1:0]          prdata,
    output logic                                pready
);
    import fdd_pkg::*;

    localparam int DEPTH = 2 ** STORE_AW;
    localparam int LW    = $clog2(FADE_LEN + 1);
    localparam logic [LW-1:0]  FADE_L   = LW'(FADE_LEN);
    // ceil(2^RECIP_SH / FADE_LEN): exact quotient for any 26-bit magnitude
    localparam int RECIP_SH = FADE_W + LW;
    localparam longint RECIP_FULL = ((longint'(1) <<< RECIP_SH) + longint'(FADE_LEN) - 1)
                                    / longint'(FADE_LEN);
    localparam logic [FADE_W+1:0] RECIP_M = (FADE_W+2)'(RECIP_FULL);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_NEW,
        ST_OLD,
        ST_DIV,
        ST_FIX,
        ST_FIN
    } state_t;

    function automatic logic signed [SAMPLE_W-1:0] sat24(input logic signed [27:0] v);
        if (v > 28'sd8388607) begin
            return 24'sh7FFFFF;
        end else if (v < -28'sd8388608) begin
            return 24'sh800000;
        end
        return v[SAMPLE_W-1:0];
    endfunction

    function automatic logic signed [FADE_W-1:0] sat26(input logic signed [27:0] v);
        if (v > 28'sd33554431) begin
            return 26'sh1FFFFFF;
        end else if (v < -28'sd33554432) begin
            return 26'sh2000000;
        end
        return v[FADE_W-1:0];
    endfunction

    // control state
    state_t                      state_reg, state_next;
    logic [STORE_AW-1:0]         wp_reg, wp_next;
    logic                        full_reg, full_next;
    logic signed [SAMPLE_W-1:0]  prev_read_reg, prev_read_next;
    logic [DELAY_W-1:0]          last_delay_reg, last_delay_next;
    logic signed [FADE_W-1:0]    fade_now_reg, fade_now_next;
    logic [LW-1:0]               frac_reg, frac_next;
    logic [LW-1:0]               fade_cnt_reg, fade_cnt_next;
    logic                        fading_reg, fading_next;
    logic [GAIN_W-1:0]           dry_reg, dry_next;
    logic [GAIN_W-1:0]           wet_reg, wet_next;
    logic [GAIN_W-1:0]           fb_reg, fb_next;
    logic                        m_valid_reg, m_valid_next;
    logic signed [SAMPLE_W-1:0]  m_out_reg, m_out_next;

    // per-item payload
    logic signed [SAMPLE_W-1:0]  x_reg, x_next;
    logic [DELAY_W-1:0]          d_reg, d_next;
    logic                        change_reg, change_next;
    logic signed [SAMPLE_W-1:0]  new_raw_reg, new_raw_next;
    logic signed [FADE_W-1:0]    fs_reg, fs_next;
    logic                        neg_reg, neg_next;
    logic [FADE_W-1:0]           div_reg, div_next;
    logic [FADE_W-1:0]           quot_reg, quot_next;
    logic signed [FADE_W-1:0]    step_a_reg, step_a_next;
    logic [LW-1:0]               step_b_reg, step_b_next;

    // delay RAM
    logic signed [SAMPLE_W-1:0]  store_mem [DEPTH];
    logic signed [SAMPLE_W-1:0]  mem_rdata_reg;
    logic                        rd_ok_reg;
    logic                        mem_re;
    logic                        mem_we;
    logic [STORE_AW-1:0]         mem_raddr;
    logic signed [SAMPLE_W-1:0]  raw_mem;

    logic [DELAY_W+STORE_AW-1:0] dext_new;
    logic [DELAY_W+STORE_AW-1:0] dext_last;
    logic [STORE_AW-1:0]         rp_new;
    logic [STORE_AW-1:0]         old_pos;

    logic                        accept;
    logic                        out_free;
    logic                        finish;
    logic                        cfg_we;
    reg_idx_t                    cfg_idx;

    // finishing arithmetic
    logic                        chg;
    logic [GAIN_W-1:0]           fb_eff;
    logic signed [FADE_W-1:0]    fnow_eff;
    logic signed [SAMPLE_W-1:0]  raw_eff;
    logic signed [SAMPLE_W-1:0]  rd_val;
    logic signed [40:0]          prod_fb;
    logic signed [41:0]          sum_fb;
    logic signed [SAMPLE_W-1:0]  rec_val;
    logic signed [40:0]          prod_dry;
    logic signed [40:0]          prod_wet;
    logic signed [41:0]          sum_y;
    logic signed [SAMPLE_W-1:0]  y_val;
    logic signed [FADE_W-1:0]    off_sat;
    logic [FADE_W-1:0]           off_mag;
    logic [2*FADE_W+1:0]         recip_prod;
    logic [FADE_W-1:0]           quot_val;
    logic [FADE_W-1:0]           rem_full;
    logic [LW-1:0]               rem_val;

    // fade update
    logic                        fading_eff;
    logic [LW-1:0]               cnt_eff;
    logic [LW-1:0]               cnt_dec;
    logic [LW-1:0]               r_eff;
    logic                        borrow;
    logic [LW-1:0]               r_step;
    logic [FADE_W:0]             q_step;
    logic signed [FADE_W-1:0]    fade_now_f;
    logic [LW-1:0]               frac_f;
    logic [LW-1:0]               cnt_f;
    logic                        fading_f;

    assign pready       = 1'b1;
    assign s_ready      = (state_reg == ST_IDLE);
    assign m_valid      = m_valid_reg;
    assign m_sample_out = m_out_reg;

    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign finish   = out_free && ((state_reg == ST_FIN) ||
                                   (state_reg == ST_NEW && !change_reg));
    assign cfg_we   = psel && penable && pwrite;
    assign cfg_idx  = reg_idx_t'(paddr[APB_AW-1:2]);

    // delay taken modulo the store depth
    assign dext_new  = {{STORE_AW{1'b0}}, s_delay_len};
    assign dext_last = {{STORE_AW{1'b0}}, last_delay_reg};
    assign rp_new    = wp_reg - dext_new[STORE_AW-1:0];
    assign old_pos   = wp_reg - dext_last[STORE_AW-1:0];

    assign mem_re    = accept || (state_reg == ST_NEW && change_reg);
    assign mem_raddr = (state_reg == ST_IDLE) ? rp_new : old_pos;
    assign mem_we    = finish;
    assign raw_mem   = rd_ok_reg ? mem_rdata_reg : '0;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            store_mem[wp_reg] <= rec_val;
        end
        if (mem_re) begin
            mem_rdata_reg <= store_mem[mem_raddr];
            // entries at or past the write pointer are unwritten until the first wrap
            rd_ok_reg     <= full_reg || (mem_raddr < wp_reg);
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_DRY: prdata = APB_DW'(dry_reg);
            REG_WET: prdata = APB_DW'(wet_reg);
            REG_FB:  prdata = APB_DW'(fb_reg);
            default: prdata = '0;
        endcase
    end

    // sample path of the final cycle
    always_comb begin
        chg      = (state_reg == ST_FIN);
        fb_eff   = (fb_reg > FB_MAX) ? FB_MAX : fb_reg;
        fnow_eff = chg ? fs_reg : fade_now_reg;
        raw_eff  = chg ? new_raw_reg : raw_mem;
        rd_val   = sat24(28'(raw_eff) + 28'(fnow_eff));

        prod_fb  = prev_read_reg * $signed({1'b0, fb_eff});
        sum_fb   = 42'(prod_fb) + 42'sd32768;
        rec_val  = sat24(28'(x_reg) + 28'($signed(sum_fb[41:16])));

        prod_dry = x_reg * $signed({1'b0, dry_reg});
        prod_wet = rd_val * $signed({1'b0, wet_reg});
        sum_y    = 42'(prod_dry) + 42'(prod_wet) + 42'sd8192;
        y_val    = sat24($signed(sum_y[41:14]));

        // offset bridging the jump from the old tap to the new one
        off_sat  = sat26(28'(raw_mem) + 28'(fade_now_reg) - 28'(new_raw_reg));
        off_mag  = off_sat[FADE_W-1] ? FADE_W'(-off_sat) : FADE_W'(off_sat);

        // magnitude / FADE_LEN by reciprocal, remainder by back-multiply
        recip_prod = (2*FADE_W+2)'(div_reg) * (2*FADE_W+2)'(RECIP_M);
        quot_val   = FADE_W'(recip_prod >> RECIP_SH);
        rem_full   = div_reg - quot_reg * FADE_W'(FADE_LEN);
        rem_val    = rem_full[LW-1:0];
    end

    // ramp kept as quotient and remainder of fade_start * count / FADE_LEN;
    // each step takes off step_a whole units and step_b remainder units
    always_comb begin
        fading_eff = chg || fading_reg;
        cnt_eff    = chg ? FADE_L : fade_cnt_reg;
        cnt_dec    = cnt_eff - LW'(1);
        r_eff      = chg ? '0 : frac_reg;
        borrow     = (r_eff < step_b_reg);
        r_step     = borrow ? (r_eff - step_b_reg + FADE_L) : (r_eff - step_b_reg);
        q_step     = (FADE_W+1)'(fnow_eff) - (FADE_W+1)'(step_a_reg) - (FADE_W+1)'(borrow);
        fade_now_f = fade_now_reg;
        frac_f     = frac_reg;
        cnt_f      = fade_cnt_reg;
        fading_f   = fading_reg;
        if (fading_eff) begin
            if (cnt_dec != '0) begin
                fade_now_f = $signed(q_step[FADE_W-1:0]);
                frac_f     = r_step;
                cnt_f      = cnt_dec;
                fading_f   = 1'b1;
            end else begin
                fade_now_f = '0;
                frac_f     = '0;
                cnt_f      = '0;
                fading_f   = 1'b0;
            end
        end
    end

    always_comb begin
        state_next      = state_reg;
        wp_next         = wp_reg;
        full_next       = full_reg;
        prev_read_next  = prev_read_reg;
        last_delay_next = last_delay_reg;
        fade_now_next   = fade_now_reg;
        frac_next       = frac_reg;
        fade_cnt_next   = fade_cnt_reg;
        fading_next     = fading_reg;
        dry_next        = dry_reg;
        wet_next        = wet_reg;
        fb_next         = fb_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_out_next      = m_out_reg;
        x_next          = x_reg;
        d_next          = d_reg;
        change_next     = change_reg;
        new_raw_next    = new_raw_reg;
        fs_next         = fs_reg;
        neg_next        = neg_reg;
        div_next        = div_reg;
        quot_next       = quot_reg;
        step_a_next     = step_a_reg;
        step_b_next     = step_b_reg;

        if (cfg_we) begin
            case (cfg_idx)
                REG_DRY: dry_next = pwdata[GAIN_W-1:0];
                REG_WET: wet_next = pwdata[GAIN_W-1:0];
                REG_FB:  fb_next  = pwdata[GAIN_W-1:0];
                default: ;
            endcase
        end

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    x_next      = s_sample_in;
                    d_next      = s_delay_len;
                    change_next = (s_delay_len != last_delay_reg);
                    state_next  = ST_NEW;
                end
            end
            ST_NEW: begin
                if (change_reg) begin
                    new_raw_next = raw_mem;
                    state_next   = ST_OLD;
                end else if (finish) begin
                    state_next = ST_IDLE;
                end
            end
            ST_OLD: begin
                fs_next    = off_sat;
                neg_next   = off_sat[FADE_W-1];
                div_next   = off_mag;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                quot_next  = quot_val;
                state_next = ST_FIX;
            end
            ST_FIX: begin
                // floor division: negative offsets round towards minus infinity
                if (!neg_reg) begin
                    step_a_next = $signed(quot_reg);
                    step_b_next = rem_val;
                end else if (rem_val == '0) begin
                    step_a_next = -$signed(quot_reg);
                    step_b_next = '0;
                end else begin
                    step_a_next = -$signed(quot_reg) - FADE_W'(1);
                    step_b_next = FADE_L - rem_val;
                end
                state_next = ST_FIN;
            end
            ST_FIN: begin
                if (finish) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase

        if (finish) begin
            wp_next         = wp_reg + STORE_AW'(1);
            full_next       = full_reg || (wp_reg == '1);
            prev_read_next  = rd_val;
            last_delay_next = d_reg;
            fade_now_next   = fade_now_f;
            frac_next       = frac_f;
            fade_cnt_next   = cnt_f;
            fading_next     = fading_f;
            m_valid_next    = 1'b1;
            m_out_next      = y_val;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            wp_reg         <= '0;
            full_reg       <= 1'b0;
            prev_read_reg  <= '0;
            last_delay_reg <= '0;
            fade_now_reg   <= '0;
            frac_reg       <= '0;
            fade_cnt_reg   <= FADE_L;
            fading_reg     <= 1'b0;
            dry_reg        <= DRY_RESET;
            wet_reg        <= WET_RESET;
            fb_reg         <= FB_RESET;
            m_valid_reg    <= 1'b0;
            m_out_reg      <= '0;
        end else begin
            state_reg      <= state_next;
            wp_reg         <= wp_next;
            full_reg       <= full_next;
            prev_read_reg  <= prev_read_next;
            last_delay_reg <= last_delay_next;
            fade_now_reg   <= fade_now_next;
            frac_reg       <= frac_next;
            fade_cnt_reg   <= fade_cnt_next;
            fading_reg     <= fading_next;
            dry_reg        <= dry_next;
            wet_reg        <= wet_next;
            fb_reg         <= fb_next;
            m_valid_reg    <= m_valid_next;
            m_out_reg      <= m_out_next;
        end
    end

    always_ff @(posedge aclk) begin
        x_reg       <= x_next;
        d_reg       <= d_next;
        change_reg  <= change_next;
        new_raw_reg <= new_raw_next;
        fs_reg      <= fs_next;
        neg_reg     <= neg_next;
        div_reg     <= div_next;
        quot_reg    <= quot_next;
        step_a_reg  <= step_a_next;
        step_b_reg  <= step_b_next;
    end

endmodule

// ===== sv/fdd_port_checker.sv =====
// ----------------------------------------------------------------------------
// fdd_port_checker
// Port-level checks of the feedback delay core, bound to the top level.
// ----------------------------------------------------------------------------
`include "feedback_delay_with_declick_core_assert.svh"

module fdd_port_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                s_valid,
    input logic                                s_ready,
    input logic signed [fdd_pkg::SAMPLE_W-1:0] s_sample_in,
    input logic [fdd_pkg::DELAY_W-1:0]         s_delay_len,
    input logic                                m_valid,
    input logic                                m_ready,
    input logic signed [fdd_pkg::SAMPLE_W-1:0] m_sample_out,
    input logic                                psel,
    input logic                                penable,
    input logic                                pwrite,
    input logic [fdd_pkg::APB_AW-1:0]          paddr,
    input logic [fdd_pkg::APB_DW-1:0]          pwdata,
    input logic [fdd_pkg::APB_DW-1:0]          prdata,
    input logic                                pready
);
    import fdd_pkg::*;

    // APB side never inserts wait states
    `FDD_ASSERT_ALWAYS(a_pready_high, aclk, aresetn, pready)

    // one item in flight: the input side is closed in the cycle after a transfer
    `FDD_ASSERT_NEXT(a_busy_after_transfer, aclk, aresetn, aresetn && s_valid && s_ready, !s_ready)

    // a new result only ever follows work done with the input side closed
    `FDD_ASSERT_NOW(a_result_after_work, aclk, aresetn, $rose(m_valid), $past(!s_ready))

    `FDD_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_sample_out))

endmodule

bind feedback_delay_with_declick_core fdd_port_checker u_fdd_port_checker (.*);
